[sv/cms_pkg.sv]
// ----------------------------------------------------------------------------
// cms_pkg
// Types and constants of the count-min sketch core.
// ----------------------------------------------------------------------------
package cms_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int MAX_DEPTH = 8;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int ADDR_W    = COL_W + ROW_W;
    localparam int WID_W     = COL_W + 1;
    localparam int DEP_W     = ROW_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 1'b1;

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_COUNT    = 3'd1,
        CMD_VALUES   = 3'd2,
        CMD_MERGE    = 3'd3,
        CMD_COMPRESS = 3'd4,
        CMD_CLEAR    = 3'd5,
        CMD_RSVD6    = 3'd6,
        CMD_RSVD7    = 3'd7
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX,
        ST_DIV,
        ST_READ,
        ST_WAIT,
        ST_UPDATE,
        ST_EMIT,
        ST_FOLD_RD_LO,
        ST_FOLD_RD_HI,
        ST_FOLD_WR,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  row_index;
        logic        last;
        logic        error;
    } result_t;

endpackage

[sv/cms_if.sv]
// ----------------------------------------------------------------------------
// cms_stream_if
// Valid/ready channel carrying a request or a result payload.
// ----------------------------------------------------------------------------
interface cms_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/count_min_sketch_core.sv]
// ----------------------------------------------------------------------------
// count_min_sketch_core
// Count-min sketch over a single-port-write counter RAM.
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass zeroes all
// MAX_DEPTH*MAX_WIDTH (8192) counters of the RAM. No request is taken during
// that pass, and clear repeats it. Add, count and values go row by row. A
// mix step starts a bit-serial modulo by the active width. Then come a RAM
// read, a wait for the data, and the update (values emits instead). Values
// holds a row for as long as its previous result is not accepted. Count
// gives its result after the last row. Merge does a read, a wait and an update.
// Compress reports first. It then walks every row, column by column of the
// lower half: two reads, the folded write and a zero write to the upper column.
// Counters wrap. Values emits depth results, and the last one is flagged.
module count_min_sketch_core (
    input  logic clk,
    input  logic rst_n,
    cms_stream_if.sink   req,
    cms_stream_if.source rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cms_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import cms_pkg::*;

    // request payload layout: command, hash_first, hash_second, amount,
    // merge_row, merge_column
    logic [2:0]  command;
    logic [31:0] hash_first, hash_second, amount;
    logic [2:0]  merge_row;
    logic [9:0]  merge_column;
    assign {command, hash_first, hash_second, amount, merge_row, merge_column} = req.data;

    state_t state_reg, state_next;

    logic [10:0]      width_cfg_reg;
    logic [3:0]       depth_cfg_reg;
    logic [WID_W-1:0] aw_reg, aw_next;
    logic [2:0]       cmd_reg;
    logic [31:0]      h2_reg, amt_reg, mix_reg, min_reg;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [31:0]      lo_reg;
    logic [ADDR_W:0]  sweep_reg, sweep_next;
    logic             err_reg;
    logic [DEP_W-1:0] depth_eff;
    logic             out_valid_reg;
    result_t          out_reg;

    logic             mod_start, mod_done;
    logic [COL_W-1:0] mod_rem;
    logic             we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [31:0]      wdata, rdata;
    logic             last_row;
    logic [WID_W-1:0] half;
    logic             req_fire;

    always_comb
    begin
        if (depth_cfg_reg == 4'd0)
            depth_eff = DEP_W'(1);
        else if (depth_cfg_reg > 4'(MAX_DEPTH))
            depth_eff = DEP_W'(MAX_DEPTH);
        else
            depth_eff = DEP_W'(depth_cfg_reg);
    end

    assign last_row = ({1'b0, row_reg} + DEP_W'(1)) == depth_eff;
    assign half     = aw_reg >> 1;

    cms_mod u_mod (
        .clk(clk), .rst_n(rst_n), .start(mod_start), .dividend(mix_reg),
        .divisor(aw_reg), .done(mod_done), .remainder(mod_rem)
    );

    cms_ram u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // a pending result sits in out_reg; the next request may start meanwhile
    assign cfg_ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_fire)
                begin
                    case (command)
                        CMD_ADD, CMD_COUNT, CMD_VALUES: state_next = ST_MIX;
                        CMD_MERGE:    state_next = ST_READ;
                        CMD_COMPRESS: state_next = ST_RESULT;
                        CMD_CLEAR:    state_next = ST_SWEEP;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            ST_MIX:    state_next = ST_DIV;
            ST_DIV:    if (mod_done) state_next = ST_READ;
            ST_READ:   state_next = ST_WAIT;
            ST_WAIT:   state_next = (cmd_reg == CMD_VALUES) ? ST_EMIT : ST_UPDATE;
            ST_UPDATE:
                if (cmd_reg == CMD_MERGE || last_row)
                    state_next = (cmd_reg == CMD_COUNT) ? ST_RESULT : ST_IDLE;
                else
                    state_next = ST_MIX;
            ST_EMIT:
                if (!out_valid_reg)
                    state_next = last_row ? ST_IDLE : ST_MIX;
            ST_FOLD_RD_LO: state_next = ST_FOLD_RD_HI;
            ST_FOLD_RD_HI: state_next = ST_FOLD_WR;
            ST_FOLD_WR:    state_next = ST_SWEEP;
            ST_SWEEP:
                if (sweep_reg[ADDR_W])
                    state_next = ST_IDLE;
                else if (cmd_reg == CMD_COMPRESS)
                    state_next = sweep_next[ADDR_W] ? ST_IDLE : ST_FOLD_RD_LO;
            ST_RESULT:
                if (!out_valid_reg)
                    state_next = (cmd_reg == CMD_COMPRESS && !err_reg && sweep_reg == '0)
                                 ? ST_FOLD_RD_LO : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // compress walks {row_reg, col_reg} over the lower half; each fold
    // step writes lo+hi at col and zero at col+half.
    logic [ADDR_W-1:0] fold_lo, fold_hi;
    assign fold_lo = {row_reg, col_reg};
    assign fold_hi = {row_reg, COL_W'({1'b0, col_reg} + half)};

    always_comb
    begin
        mod_start = (state_reg == ST_MIX);
        we        = 1'b0;
        waddr     = {row_reg, col_reg};
        wdata     = lo_reg + rdata;
        raddr     = {row_reg, col_reg};
        unique case (state_reg)
            ST_READ:
                if (cmd_reg != CMD_MERGE)
                    raddr = {row_reg, mod_rem};
            ST_UPDATE:
                if (cmd_reg == CMD_ADD || cmd_reg == CMD_MERGE)
                begin
                    we    = (cmd_reg == CMD_ADD) || err_reg == 1'b0;
                    wdata = amt_reg + rdata;
                end
            ST_FOLD_RD_LO: raddr = fold_lo;
            ST_FOLD_RD_HI: raddr = fold_hi;
            ST_FOLD_WR:
            begin
                we    = 1'b1;
                waddr = fold_lo;
                wdata = lo_reg + rdata;
            end
            ST_SWEEP:
            begin
                we    = !sweep_reg[ADDR_W];
                wdata = '0;
                if (cmd_reg == CMD_COMPRESS)
                    waddr = fold_hi;
                else
                    waddr = sweep_reg[ADDR_W-1:0];
            end
            default: ;
        endcase
    end

    // datapath registers
    logic [ROW_W:0] row_sum;
    assign row_sum = {1'b0, row_reg} + (ROW_W+1)'(1);

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        sweep_next = sweep_reg;
        aw_next    = aw_reg;
        if (req_fire)
        begin
            row_next   = (command == CMD_MERGE) ? ROW_W'(merge_row) : '0;
            col_next   = (command == CMD_MERGE) ? COL_W'(merge_column) : '0;
            sweep_next = '0;
        end
        // hold the hashed column for the wait and update cycles
        if (state_reg == ST_READ && cmd_reg != CMD_MERGE)
            col_next = mod_rem;
        if (state_reg == ST_SWEEP && !sweep_reg[ADDR_W])
        begin
            if (cmd_reg == CMD_COMPRESS)
            begin
                // advance over rows x lower half
                if ({1'b0, col_reg} + WID_W'(1) == half)
                begin
                    col_next = '0;
                    row_next = row_sum[ROW_W-1:0];
                    if (row_sum[ROW_W] || row_sum == (ROW_W+1)'(MAX_DEPTH))
                    begin
                        sweep_next = {1'b1, {ADDR_W{1'b0}}};
                        aw_next    = half;
                    end
                end
                else
                    col_next = col_reg + COL_W'(1);
            end
            else
                sweep_next = sweep_reg + (ADDR_W+1)'(1);
        end
        if (state_reg == ST_SWEEP && sweep_reg[ADDR_W] && cmd_reg == CMD_CLEAR)
        begin
            if (width_cfg_reg == 11'd0)
                aw_next = WID_W'(1);
            else if (width_cfg_reg > 11'(MAX_WIDTH))
                aw_next = WID_W'(MAX_WIDTH);
            else
                aw_next = WID_W'(width_cfg_reg);
        end
        if (state_reg == ST_UPDATE || (state_reg == ST_EMIT && !out_valid_reg))
            row_next = row_sum[ROW_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            cmd_reg       <= CMD_CLEAR;
            sweep_reg     <= '0;
            width_cfg_reg <= 11'd1024;
            depth_cfg_reg <= 4'd4;
            aw_reg        <= WID_W'(MAX_WIDTH);
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            err_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            sweep_reg <= sweep_next;
            aw_reg    <= aw_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_WIDTH: width_cfg_reg <= cfg_data;
                    REG_DEPTH: depth_cfg_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;
            if (req_fire)
            begin
                cmd_reg <= command;
                if (command == CMD_MERGE)
                    err_reg <= !(({1'b0, merge_row} < 4'(depth_eff))
                                 && ({1'b0, merge_column} < aw_reg));
                else if (command == CMD_COMPRESS)
                    err_reg <= (aw_reg < WID_W'(2)) || ((aw_reg & (aw_reg - WID_W'(1))) != '0);
                else
                    err_reg <= 1'b0;
            end
            if (state_reg == ST_EMIT && !out_valid_reg)
            begin
                out_valid_reg     <= 1'b1;
                out_reg.value     <= lo_reg;
                out_reg.row_index <= 3'(row_reg);
                out_reg.last      <= last_row;
                out_reg.error     <= 1'b0;
            end
            if (state_reg == ST_RESULT && !out_valid_reg)
            begin
                // compress reports on entry (before the fold), count after
                if (cmd_reg == CMD_COUNT || sweep_reg == '0 || err_reg)
                begin
                    out_valid_reg     <= 1'b1;
                    out_reg.value     <= (cmd_reg == CMD_COUNT) ? min_reg : 32'd0;
                    out_reg.row_index <= 3'd0;
                    out_reg.last      <= 1'b1;
                    out_reg.error     <= (cmd_reg == CMD_COMPRESS) && err_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_fire)
        begin
            h2_reg  <= hash_second;
            amt_reg <= amount;
            min_reg <= 32'hFFFF_FFFF;
            mix_reg <= hash_first;
        end
        if (state_reg == ST_UPDATE)
            mix_reg <= mix_reg + h2_reg;
        if (state_reg == ST_EMIT && !out_valid_reg)
            mix_reg <= mix_reg + h2_reg;
        if (state_reg == ST_WAIT)
            lo_reg <= rdata;
        if (state_reg == ST_UPDATE && cmd_reg == CMD_COUNT && rdata < min_reg)
            min_reg <= rdata;
        if (state_reg == ST_FOLD_RD_HI)
            lo_reg <= rdata;
    end
endmodule

[sv/cms_mod.sv]
// ----------------------------------------------------------------------------
// cms_mod
// Bit-serial unsigned 32-bit modulo by the active width (one bit a cycle).
// ----------------------------------------------------------------------------
module cms_mod (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [31:0]          dividend,
    input  logic [cms_pkg::WID_W-1:0] divisor,
    output logic                 done,
    output logic [cms_pkg::COL_W-1:0] remainder
);
    import cms_pkg::*;

    logic [31:0]    dvd_reg, dvd_next;
    logic [WID_W:0] rem_reg, rem_next;
    logic [5:0]     cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic [WID_W:0] shifted;

    assign shifted = {rem_reg[WID_W-1:0], dvd_reg[31]};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[30:0], 1'b0};
            if (shifted >= {1'b0, divisor})
                rem_next = shifted - {1'b0, divisor};
            else
                rem_next = shifted;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done      = busy_reg && (cnt_reg == 6'd31);
    assign remainder = rem_next[COL_W-1:0];
endmodule

[sv/cms_ram.sv]
// ----------------------------------------------------------------------------
// cms_ram
// Counter store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cms_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [cms_pkg::ADDR_W-1:0] waddr,
    input  logic [31:0]                wdata,
    input  logic [cms_pkg::ADDR_W-1:0] raddr,
    output logic [31:0]                rdata
);
    import cms_pkg::*;

    logic [31:0] mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
